// ===== rtl/brp_pkg.sv =====
`timescale 1ns / 1ps
package brp_pkg;

   localparam int MAX_WORDS_DEFAULT = 8;
   localparam int QUEUE_DEPTH       = 2;

   localparam int SIG_W       = 64;
   localparam int KIND_W      = 3;
   localparam int WC_W        = 4;
   localparam int EXP_IN_W    = 16;
   localparam int ADJ_W       = 18;
   localparam int EXP_W       = 12;
   localparam int SHIFT_W     = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;

   localparam int EXP_BIAS       = 1023;
   localparam int EXP_MAX        = 1023;
   localparam int EXP_NORM_MIN   = -1022;
   localparam int EXP_UNF_PRE    = -1022 - 53;
   localparam int EXP_UNF_POST   = -1022 - 52;
   localparam int NORMAL_SHIFT   = 11;
   localparam int SUBNORM_OFFSET = 1011;

   localparam logic [SIG_W-1:0] EXP_ALL_BITS = 64'h7FF0_0000_0000_0000;
   localparam logic [SIG_W-1:0] FLT_MAX_BITS = 64'h47EF_FFFF_E000_0000;
   localparam logic [SIG_W-1:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROUNDING_MODE         = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERFLOW_TO_FLOAT_MAX = CSR_INDEX_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_VALUE       = 3'd0,
      KIND_ZERO        = 3'd1,
      KIND_INFINITY    = 3'd2,
      KIND_OVERFLOW    = 3'd3,
      KIND_UNDERFLOW   = 3'd4,
      KIND_NAN_DEFAULT = 3'd5,
      KIND_NAN_PAYLOAD = 3'd6
   } brp_kind_type;

   typedef enum logic [1:0] {
      RM_TOWARD_ZERO  = 2'd0,
      RM_NEAREST_EVEN = 2'd1,
      RM_TOWARD_POS   = 2'd2,
      RM_TOWARD_NEG   = 2'd3
   } brp_round_type;

   typedef enum logic [1:0] {
      CLS_FINITE,
      CLS_FIXED,
      CLS_OVERFLOW,
      CLS_UNDERFLOW
   } brp_class_type;

   typedef struct packed {
      brp_class_type      cls;
      logic               sign;
      logic [SIG_W-1:0]   sig;
      logic               sticky;
      logic [EXP_W-1:0]   exp;
      logic [SHIFT_W-1:0] shift;
   } brp_item_type;

   typedef struct packed {
      brp_round_type rounding_mode;
      logic          overflow_to_float_max;
   } brp_cfg_type;

endpackage

// ===== rtl/brp_if.sv =====
`timescale 1ns / 1ps
interface brp_req_if;
   import brp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic                   sign;
   logic [SIG_W-1:0]       significand;
   logic                   more_nonzero;
   logic [WC_W-1:0]        word_count;
   logic signed [EXP_IN_W-1:0] exponent;

   modport source (
      output valid, kind, sign, significand, more_nonzero, word_count, exponent,
      input  ready
   );
   modport sink (
      input  valid, kind, sign, significand, more_nonzero, word_count, exponent,
      output ready
   );
endinterface

interface brp_rsp_if;
   import brp_pkg::*;

   logic             valid;
   logic             ready;
   logic [SIG_W-1:0] double_bits;
   logic             range_error;

   modport source (output valid, double_bits, range_error, input ready);
   modport sink (input valid, double_bits, range_error, output ready);
endinterface

// ===== rtl/brp_front.sv =====
`timescale 1ns / 1ps
module brp_front #(
   parameter int MAX_WORDS = brp_pkg::MAX_WORDS_DEFAULT
) (
   brp_req_if.sink              req,
   output brp_pkg::brp_item_type item,
   output logic                 push_valid,
   input  logic                 push_ready
);
   import brp_pkg::*;

   logic [WC_W-1:0]         wc_eff;
   logic [SIG_W-1:0]        sig_eff;
   logic signed [ADJ_W-1:0] adj;
   logic [ADJ_W-1:0]        shift_wide;

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   always_comb begin
      wc_eff = req.word_count;
      if (req.word_count == '0) begin
         wc_eff = WC_W'(1);
      end else if (int'(req.word_count) > MAX_WORDS) begin
         wc_eff = WC_W'(MAX_WORDS);
      end
      sig_eff = (wc_eff == WC_W'(1)) ? {req.significand[SIG_W-1:32], 32'b0}
                                     : req.significand;
      adj = {{(ADJ_W-EXP_IN_W){req.exponent[EXP_IN_W-1]}}, req.exponent}
            + ADJ_W'({wc_eff, 5'b0}) - ADJ_W'(1);
      shift_wide = ADJ_W'(-adj) - ADJ_W'(SUBNORM_OFFSET);
   end

   always_comb begin
      item.cls    = CLS_FIXED;
      item.sign   = req.sign;
      item.sig    = '0;
      item.sticky = req.more_nonzero && (wc_eff > WC_W'(2));
      item.exp    = adj[EXP_W-1:0];
      item.shift  = (adj >= ADJ_W'(EXP_NORM_MIN)) ? SHIFT_W'(NORMAL_SHIFT)
                                                  : shift_wide[SHIFT_W-1:0];
      unique case (req.kind)
         KIND_VALUE: begin
            item.sig = sig_eff;
            if (adj > ADJ_W'(EXP_MAX)) begin
               item.cls = CLS_OVERFLOW;
            end else if (adj < ADJ_W'(EXP_UNF_PRE)) begin
               item.cls = CLS_UNDERFLOW;
            end else begin
               item.cls = CLS_FINITE;
            end
         end
         KIND_INFINITY:    item.sig = EXP_ALL_BITS;
         KIND_OVERFLOW:    item.cls = CLS_OVERFLOW;
         KIND_UNDERFLOW:   item.cls = CLS_UNDERFLOW;
         KIND_NAN_DEFAULT: item.sig = QNAN_BITS;
         KIND_NAN_PAYLOAD: begin
            item.sig = {1'b0, 11'h7FF, 1'b1, sig_eff[62:32], sig_eff[31:12]};
         end
         default:          item.sig = '0;
      endcase
   end

endmodule

// ===== rtl/brp_queue.sv =====
`timescale 1ns / 1ps
module brp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  brp_pkg::brp_item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output brp_pkg::brp_item_type pop_item
);
   import brp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   brp_item_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count missed a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop_fire && !push_fire |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count missed a pop");

endmodule

// ===== rtl/brp_back.sv =====
`timescale 1ns / 1ps
module brp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  brp_pkg::brp_cfg_type  cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  brp_pkg::brp_item_type item,
   brp_rsp_if.source             rsp
);
   import brp_pkg::*;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SIG_W-1:0]        bits_ff, bits_in;
   logic                    rerr_ff, rerr_in;

   logic [5:0]              sh_m1;
   logic [SIG_W-1:0]        shifted;
   logic                    half;
   logic [52:0]             kept;
   logic                    rest_nz;
   logic                    sticky_all;
   logic                    inc;
   logic [53:0]             kept_inc;
   logic [53:0]             kept_r;
   logic [SIG_W-1:0]        kept_ext;
   logic [SHIFT_W-1:0]      carry_sel;
   logic                    carry;
   logic signed [EXP_W-1:0] e_fin;
   logic [EXP_W-1:0]        bias_sum;
   logic                    ovf, unf, sign_out;
   logic [SIG_W-1:0]        ovf_bits;
   logic                    load;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      sh_m1      = 6'(item.shift - SHIFT_W'(1));
      shifted    = item.sig >> sh_m1;
      half       = shifted[0];
      kept       = shifted[53:1];
      rest_nz    = (item.sig & ((64'd1 << sh_m1) - 64'd1)) != '0;
      sticky_all = item.sticky || rest_nz;
      case (cfg.rounding_mode)
         RM_NEAREST_EVEN: inc = half && (sticky_all || kept[0]);
         RM_TOWARD_POS:   inc = !item.sign && (half || sticky_all);
         RM_TOWARD_NEG:   inc = item.sign && (half || sticky_all);
         default:         inc = 1'b0;
      endcase
      kept_inc  = {1'b0, kept} + 54'd1;
      kept_ext  = {10'b0, kept_inc};
      carry_sel = SHIFT_W'(SIG_W) - item.shift;
      carry     = inc && kept_ext[carry_sel[5:0]];
      kept_r    = inc ? kept_inc : {1'b0, kept};
      e_fin     = $signed(item.exp) + $signed({{(EXP_W-1){1'b0}}, carry});
      bias_sum  = e_fin + EXP_W'(EXP_BIAS);
      ovf_bits  = cfg.overflow_to_float_max ? FLT_MAX_BITS : EXP_ALL_BITS;
   end

   always_comb begin
      ovf      = 1'b0;
      unf      = 1'b0;
      bits_in  = item.sig;
      case (item.cls)
         CLS_OVERFLOW:  ovf = 1'b1;
         CLS_UNDERFLOW: unf = 1'b1;
         CLS_FINITE: begin
            ovf = e_fin > EXP_W'(EXP_MAX);
            unf = e_fin < EXP_W'(EXP_UNF_POST);
            if (e_fin >= EXP_W'(EXP_NORM_MIN)) begin
               bits_in = {1'b0, bias_sum[10:0], kept_r[51:0]};
            end else begin
               bits_in = {10'b0, kept_r};
            end
         end
         default:       bits_in = item.sig;
      endcase
      sign_out = item.sign;
      rerr_in  = ovf || unf;
      if (ovf) begin
         bits_in = ovf_bits;
      end else if (unf) begin
         bits_in  = '0;
         sign_out = 1'b0;
      end
      bits_in[SIG_W-1] = bits_in[SIG_W-1] | sign_out;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bits_ff <= bits_in;
         rerr_ff <= rerr_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.double_bits = bits_ff;
   assign rsp.range_error = rerr_ff;

   a_underflow_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rerr_ff && bits_ff[62:0] == '0 |-> !bits_ff[63])
      else $error("underflow result carries a sign");

   a_range_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rerr_ff |-> bits_ff[62:0] == '0
         || bits_ff[62:0] == EXP_ALL_BITS[62:0]
         || bits_ff[62:0] == FLT_MAX_BITS[62:0])
      else $error("range error with a finite in-range pattern");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded transaction not presented");

endmodule

// ===== rtl/binary64_round_and_pack.sv =====
// Rounds a classified number (kind, sign, 64-bit significand with sticky flag,
// word count, binary exponent) to an IEEE binary64 pattern plus a range-error
// flag. One transaction is accepted per cycle while the queue has room; each
// result is written by the classify stage into a two-entry queue, then the
// round-and-pack stage loads it into the output register. The request side keeps
// accepting while a result waits on rsp_chan.ready until the queue fills.
// Write rounding mode and overflow behavior through the csr port only while no
// transaction is in flight.
`timescale 1ns / 1ps
module binary64_round_and_pack #(
   parameter int MAX_WORDS = brp_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   brp_req_if.sink                            req_chan,
   brp_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [brp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [brp_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import brp_pkg::*;

   brp_cfg_type  cfg_ff, cfg_in;
   brp_item_type front_item, queue_item;
   logic         push_valid, push_ready;
   logic         pop_valid, pop_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROUNDING_MODE:         cfg_in.rounding_mode = brp_round_type'(csr_write_data);
            CSR_OVERFLOW_TO_FLOAT_MAX: cfg_in.overflow_to_float_max = csr_write_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rounding_mode         <= RM_NEAREST_EVEN;
         cfg_ff.overflow_to_float_max <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brp_front #(
      .MAX_WORDS (MAX_WORDS)
   ) u_front (
      .req        (req_chan),
      .item       (front_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   brp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (front_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (queue_item)
   );

   brp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .item      (queue_item),
      .rsp       (rsp_chan)
   );

endmodule

// ===== sim/tb_binary64_round_and_pack.sv =====
`timescale 1ns / 1ps
module tb_binary64_round_and_pack;
   import brp_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam logic [SIG_W-1:0]  FRAC_MASK   = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [SIG_W-1:0]  TOP_ONE     = 64'h8000_0000_0000_0000;
   localparam int                FRAC_W      = 52;
   localparam int                PHASES      = 8;
   localparam int                RANDOM_PER_PHASE = 185;
   localparam int                MAX_PRINTED = 20;
   localparam logic [WC_W-1:0]   WC0         = WC_W'(0);
   localparam logic [WC_W-1:0]   WC1         = WC_W'(1);
   localparam logic [WC_W-1:0]   WC2         = WC_W'(2);
   localparam logic [WC_W-1:0]   WC3         = WC_W'(3);
   localparam logic [WC_W-1:0]   WC4         = WC_W'(4);
   localparam logic [WC_W-1:0]   WC8         = WC_W'(8);
   localparam logic [WC_W-1:0]   WC15        = WC_W'(15);

   typedef struct {
      logic [KIND_W-1:0]          kind;
      logic                       sign;
      logic [SIG_W-1:0]           significand;
      logic                       more_nonzero;
      logic [WC_W-1:0]            word_count;
      logic signed [EXP_IN_W-1:0] exponent;
   } conv_req_type;

   typedef struct {
      logic [SIG_W-1:0] double_bits;
      logic             range_error;
   } double_result_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_style_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   brp_req_if req_chan ();
   brp_rsp_if rsp_chan ();

   binary64_round_and_pack dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   conv_req_type      pending_conversions[$];
   double_result_type expected_doubles[$];

   brp_round_type cur_mode = RM_NEAREST_EVEN;
   logic          cur_fmax = 1'b0;

   brp_round_type phase_mode [PHASES] = '{RM_NEAREST_EVEN, RM_TOWARD_ZERO, RM_TOWARD_POS,
      RM_TOWARD_NEG, RM_TOWARD_POS, RM_TOWARD_NEG, RM_TOWARD_ZERO, RM_NEAREST_EVEN};
   logic phase_fmax [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   int error_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int range_error_count = 0;
   int directed_count = 0;
   logic req_taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_tick = 0;
   stall_style_type stall_style = STALL_NONE;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int words_used(logic [WC_W-1:0] wc);
      if (wc < 1) return 1;
      if (wc > MAX_WORDS_DEFAULT) return MAX_WORDS_DEFAULT;
      return int'(wc);
   endfunction

   function automatic logic signed [EXP_IN_W-1:0] exp_for(int target, logic [WC_W-1:0] wc);
      return EXP_IN_W'(target - 32 * words_used(wc) + 1);
   endfunction

   function automatic conv_req_type conv_req(logic [KIND_W-1:0] kind, logic sign,
                                             logic [SIG_W-1:0] sig, logic more,
                                             logic [WC_W-1:0] wc,
                                             logic signed [EXP_IN_W-1:0] exponent);
      conv_req_type r;
      r.kind = kind;
      r.sign = sign;
      r.significand = sig;
      r.more_nonzero = more;
      r.word_count = wc;
      r.exponent = exponent;
      return r;
   endfunction

   function automatic double_result_type predict_double(conv_req_type r);
      double_result_type res;
      logic [SIG_W-1:0] sig, kept, rest;
      int words, adj, sh;
      logic neg, sticky, half, bump, too_big, too_small;
      sig = r.significand;
      neg = r.sign;
      words = words_used(r.word_count);
      if (words == 1) sig[31:0] = '0;
      res.double_bits = '0;
      res.range_error = 1'b0;
      too_big = 1'b0;
      too_small = 1'b0;
      case (r.kind)
         KIND_VALUE: begin
            adj = int'(r.exponent) + 32 * words - 1;
            sticky = r.more_nonzero && words > 2;
            if (adj > EXP_MAX) too_big = 1'b1;
            else if (adj < EXP_UNF_PRE) too_small = 1'b1;
            else begin
               sh = (adj >= EXP_NORM_MIN) ? NORMAL_SHIFT : -adj - SUBNORM_OFFSET;
               if (sh >= SIG_W) begin
                  kept = '0;
                  half = sig[SIG_W-1];
                  rest = {1'b0, sig[SIG_W-2:0]};
               end else begin
                  kept = sig >> sh;
                  half = sig[sh-1];
                  rest = sig & ((64'd1 << (sh - 1)) - 64'd1);
               end
               sticky = sticky || rest != '0;
               case (cur_mode)
                  RM_NEAREST_EVEN: bump = half && (sticky || kept[0]);
                  RM_TOWARD_POS:   bump = !neg && (half || sticky);
                  RM_TOWARD_NEG:   bump = neg && (half || sticky);
                  default:         bump = 1'b0;
               endcase
               if (bump) begin
                  kept = kept + 64'd1;
                  if ((kept >> (SIG_W - sh)) != '0) adj = adj + 1;
               end
               if (adj > EXP_MAX) too_big = 1'b1;
               else if (adj < EXP_UNF_POST) too_small = 1'b1;
               else if (adj >= EXP_NORM_MIN)
                  res.double_bits = (64'(adj + EXP_BIAS) << FRAC_W) | (kept & FRAC_MASK);
               else
                  res.double_bits = kept;
            end
         end
         KIND_INFINITY:    res.double_bits = EXP_ALL_BITS;
         KIND_OVERFLOW:    too_big = 1'b1;
         KIND_UNDERFLOW:   too_small = 1'b1;
         KIND_NAN_DEFAULT: res.double_bits = QNAN_BITS;
         KIND_NAN_PAYLOAD:
            res.double_bits = EXP_ALL_BITS | {12'h000, sig[63:32] | 32'h8000_0000, sig[31:12]};
         default: res.double_bits = '0;
      endcase
      if (too_big) begin
         res.range_error = 1'b1;
         res.double_bits = cur_fmax ? FLT_MAX_BITS : EXP_ALL_BITS;
      end
      if (too_small) begin
         res.range_error = 1'b1;
         neg = 1'b0;
         res.double_bits = '0;
      end
      if (neg) res.double_bits[SIG_W-1] = 1'b1;
      return res;
   endfunction

   function automatic conv_req_type rand_conversion();
      conv_req_type r;
      int pick, target, cut;
      logic [SIG_W-1:0] mask, half_bit;
      r.sign = 1'($urandom_range(0, 1));
      r.more_nonzero = 1'($urandom_range(0, 1));
      r.significand = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 6) r.word_count = '0;
      else if (pick < 12) r.word_count = WC_W'($urandom_range(9, 15));
      else r.word_count = WC_W'($urandom_range(1, MAX_WORDS_DEFAULT));
      r.exponent = EXP_IN_W'($urandom);
      if ($urandom_range(0, 99) >= 75) begin
         r.kind = KIND_W'($urandom_range(1, 7));
         return r;
      end
      r.kind = KIND_VALUE;
      pick = $urandom_range(0, 99);
      if (pick < 80) r.significand[SIG_W-1] = 1'b1;
      else if (pick >= 90) r.significand = r.significand >> $urandom_range(1, 63);
      pick = $urandom_range(0, 99);
      if (pick < 45) target = int'($urandom_range(0, 2045)) - 1022;
      else if (pick < 60) target = int'($urandom_range(0, 8)) + 1018;
      else if (pick < 88) target = int'($urandom_range(0, 64)) - 1080;
      else return r;
      r.exponent = exp_for(target, r.word_count);
      cut = (target >= EXP_NORM_MIN) ? NORMAL_SHIFT : -target - SUBNORM_OFFSET;
      if (cut > SIG_W) cut = SIG_W;
      mask = (cut >= SIG_W) ? '1 : ((64'd1 << cut) - 64'd1);
      half_bit = 64'd1 << (cut - 1);
      case ($urandom_range(0, 9))
         0: r.significand = (r.significand & ~mask) | half_bit;
         1: r.significand = (r.significand & ~mask) | (half_bit - 64'd1);
         2: r.significand = (r.significand & ~mask) | half_bit | 64'd1;
         3: r.significand = r.significand | mask;
         4: r.significand = '1;
         5: r.significand = r.significand & ~mask;
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [SIG_W-1:0] got, logic [SIG_W-1:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
                  result_count);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_ROUNDING_MODE:         cur_mode = brp_round_type'(data[1:0]);
         CSR_OVERFLOW_TO_FLOAT_MAX: cur_fmax = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_conversions.size() != 0 || req_chan.valid || expected_doubles.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      conv_req_type r;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (gap_left > 0 || pending_conversions.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_chan.valid <= 1'b0;
         end else begin
            r = pending_conversions.pop_front();
            req_chan.kind <= r.kind;
            req_chan.sign <= r.sign;
            req_chan.significand <= r.significand;
            req_chan.more_nonzero <= r.more_nonzero;
            req_chan.word_count <= r.word_count;
            req_chan.exponent <= r.exponent;
            req_chan.valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Receiver: periodically switch to a randomly chosen stall behavior.
   always @(negedge clock) begin
      if (stall_tick % 128 == 0) stall_style = stall_style_type'($urandom_range(0, 3));
      stall_tick++;
      case (stall_style)
         STALL_NONE:  rsp_chan.ready <= 1'b1;
         STALL_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_chan.ready <= ((stall_tick % 48) >= 36);
      endcase
   end

   always @(posedge clock) begin
      conv_req_type r;
      double_result_type want;
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         r.kind = req_chan.kind;
         r.sign = req_chan.sign;
         r.significand = req_chan.significand;
         r.more_nonzero = req_chan.more_nonzero;
         r.word_count = req_chan.word_count;
         r.exponent = req_chan.exponent;
         expected_doubles.push_back(predict_double(r));
         accepted_count++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         if (rsp_chan.range_error) range_error_count++;
         if (expected_doubles.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_chan.double_bits, '0);
         end else begin
            want = expected_doubles.pop_front();
            if (rsp_chan.double_bits !== want.double_bits)
               report_mismatch("double_bits", rsp_chan.double_bits, want.double_bits);
            if (rsp_chan.range_error !== want.range_error)
               report_mismatch("range_error", 64'(rsp_chan.range_error),
                               64'(want.range_error));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind = '0;
      req_chan.sign = 1'b0;
      req_chan.significand = '0;
      req_chan.more_nonzero = 1'b0;
      req_chan.word_count = '0;
      req_chan.exponent = '0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(CSR_ROUNDING_MODE, CSR_DATA_W'(phase_mode[ph]));
         write_csr(CSR_OVERFLOW_TO_FLOAT_MAX, CSR_DATA_W'(phase_fmax[ph]));
         @(posedge clock);
         if (ph == 0) begin
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, TOP_ONE, 1'b0, WC2,
                                                   exp_for(0, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, 64'hFFFF_FFFF_FFFF_F800,
                                                   1'b0, WC2, exp_for(EXP_MAX, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, '1, 1'b0, WC2,
                                                   exp_for(EXP_MAX, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, TOP_ONE, 1'b0, WC3,
                                                   exp_for(EXP_MAX + 1, WC3)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, TOP_ONE, 1'b0, WC2,
                                                   exp_for(EXP_NORM_MIN, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, '1, 1'b0, WC2,
                                                   exp_for(EXP_NORM_MIN - 1, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, TOP_ONE, 1'b0, WC2,
                                                   exp_for(EXP_UNF_POST, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, TOP_ONE, 1'b0, WC2,
                                                   exp_for(EXP_UNF_PRE, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, 64'hC000_0000_0000_0000,
                                                   1'b0, WC2, exp_for(EXP_UNF_PRE, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, TOP_ONE, 1'b0, WC2,
                                                   exp_for(EXP_UNF_PRE - 1, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, 64'h8000_0000_0000_0400,
                                                   1'b0, WC2, exp_for(0, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, 64'h8000_0000_0000_0C00,
                                                   1'b0, WC2, exp_for(0, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, 64'h8000_0000_0000_0400,
                                                   1'b1, WC3, exp_for(0, WC3)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, 64'h8000_0000_0000_0400,
                                                   1'b1, WC2, exp_for(0, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, 64'hABCD_1234_5678_9ABC,
                                                   1'b0, WC1, exp_for(5, WC1)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, 64'h8000_0000_0000_0001,
                                                   1'b1, WC0, exp_for(3, WC0)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, '1, 1'b1, WC15,
                                                   exp_for(-7, WC15)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, 64'h0000_0001_0000_0000,
                                                   1'b0, WC2, exp_for(10, WC2)));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b0, TOP_ONE, 1'b0, WC4,
                                                   16'h7FFF));
            pending_conversions.push_back(conv_req(KIND_VALUE, 1'b1, TOP_ONE, 1'b0, WC4,
                                                   16'h8000));
            pending_conversions.push_back(conv_req(KIND_ZERO, 1'b1, '0, 1'b0, WC2, '0));
            pending_conversions.push_back(conv_req(KIND_INFINITY, 1'b1, '0, 1'b0, WC2, '0));
            pending_conversions.push_back(conv_req(KIND_OVERFLOW, 1'b1, '0, 1'b0, WC2, '0));
            pending_conversions.push_back(conv_req(KIND_UNDERFLOW, 1'b1, '0, 1'b0, WC2, '0));
            pending_conversions.push_back(conv_req(KIND_NAN_DEFAULT, 1'b1, '0, 1'b0, WC2, '0));
            pending_conversions.push_back(conv_req(KIND_NAN_PAYLOAD, 1'b0,
                                                   64'h1234_5678_9ABC_DEF0, 1'b0, WC2, '0));
            pending_conversions.push_back(conv_req(KIND_NAN_PAYLOAD, 1'b1,
                                                   64'h0000_0001_FFFF_FFFF, 1'b0, WC1, '0));
            pending_conversions.push_back(conv_req(KIND_UNUSED, 1'b1, '1, 1'b1, WC8, '1));
            directed_count = pending_conversions.size();
         end
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            pending_conversions.push_back(rand_conversion());
         wait_idle();
      end

      repeat (10) @(negedge clock);
      $display("Ran %0d conversions (%0d directed) over %0d rounding/overflow settings.",
               accepted_count, directed_count, PHASES);
      $display("Checked %0d results, %0d of them flagged with a range error.",
               result_count, range_error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still outstanding", expected_doubles.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/brp_pkg.sv
rtl/brp_if.sv
rtl/brp_front.sv
rtl/brp_queue.sv
rtl/brp_back.sv
rtl/binary64_round_and_pack.sv
sim/tb_binary64_round_and_pack.sv
